// ===== hdl/dls_pkg.sv =====
// dls_pkg: shared types and constants of the Datalog token scanner.
// Holds scan mode codes, token kind codes, character codes and keyword text.
// No dependencies.
package dls_pkg;

  // Scan mode, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE  = 9'b000000001,
    MODE_COLON = 9'b000000010,
    MODE_STR   = 9'b000000100,
    MODE_STRQ  = 9'b000001000,
    MODE_HASH  = 9'b000010000,
    MODE_LCOM  = 9'b000100000,
    MODE_BCOM  = 9'b001000000,
    MODE_BBAR  = 9'b010000000,
    MODE_ID    = 9'b100000000
  } mode_t;

  // Token kinds
  localparam int unsigned KIND_W = 5;
  localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_COLON     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_COLONDASH = 5'd8;
  localparam logic [KIND_W-1:0] KIND_STRING    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_KW0       = 5'd10;
  localparam logic [KIND_W-1:0] KIND_ID        = 5'd14;
  localparam logic [KIND_W-1:0] KIND_UNDEF     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_EOF       = 5'd16;

  // Character codes
  localparam logic [7:0] CH_EOT   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // Valid flags of the two result slots produced for one character
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Keyword text, first character in the top byte, zero padded to 7 bytes
  function automatic logic [55:0] kw_text(input logic [1:0] k);
    logic [55:0] t;
    case (k)
      2'd0:    t = "Schemes";
      2'd1:    t = {"Facts", 16'h0};
      2'd2:    t = {"Rules", 16'h0};
      2'd3:    t = "Queries";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd7;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd5;
      2'd3:    n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [55:0] t;
    logic [7:0]  c;
    t = kw_text(k);
    c = (pos < 3'd7) ? t[8*(6 - int'(pos)) +: 8] : 8'h00;
    return c;
  endfunction

  // Single-character symbol tokens: , . ? ( ) * +
  function automatic logic [3:0] sym_code(input logic [7:0] c);
    logic [3:0] r;  // {hit, index}
    case (c)
      8'h2C:   r = 4'b1000;
      8'h2E:   r = 4'b1001;
      8'h3F:   r = 4'b1010;
      8'h28:   r = 4'b1011;
      8'h29:   r = 4'b1100;
      8'h2A:   r = 4'b1101;
      8'h2B:   r = 4'b1110;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dls_core.sv =====
// dls_core: scan mode, line and token bookkeeping of the token scanner.
// Turns one character into up to two packed tokens combinationally.
// Depends on dls_pkg.
module dls_core #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 12,
  parameter int unsigned ENTRY_W     = 1 + dls_pkg::KIND_W + LINE_BITS + LENGTH_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         ch,
  output dls_pkg::push_t     push,
  output logic [ENTRY_W-1:0] tok0,
  output logic [ENTRY_W-1:0] tok1
);

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  dls_pkg::mode_t          mode, mode_next;
  logic [LINE_BITS-1:0]    line, line_next;
  logic [LINE_BITS-1:0]    tsl, tsl_next;
  logic [LENGTH_BITS-1:0]  len, len_next;
  logic [3:0]              kw, kw_next;

  logic [LINE_BITS-1:0]    line_sat;
  logic [LENGTH_BITS-1:0]  len_sat;
  logic                    is_alpha, is_digit, is_ws;
  logic [3:0]              sym;
  logic [dls_pkg::KIND_W-1:0] id_kind;

  logic                       do_idle;
  logic                       pend_v, idle_v;
  logic [dls_pkg::KIND_W-1:0] pend_kind, idle_kind;
  logic [LINE_BITS-1:0]       pend_line, idle_line;
  logic [LENGTH_BITS-1:0]     pend_len, idle_len;

  // Clear keyword bits that the next identifier character rules out
  function automatic logic [3:0] kw_step(input logic [3:0] m,
                                         input logic [LENGTH_BITS-1:0] l,
                                         input logic [7:0] c);
    logic [3:0] r;
    r = m;
    for (int k = 0; k < 4; k++) begin
      if (l >= LENGTH_BITS'(dls_pkg::kw_len(2'(k))) ||
          dls_pkg::kw_char(2'(k), l[2:0]) != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Character classes and saturating counters
  assign is_alpha = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  assign is_digit = (ch >= "0" && ch <= "9");
  assign is_ws    = (ch == dls_pkg::CH_SPACE) || (ch == dls_pkg::CH_TAB) ||
                    (ch == dls_pkg::CH_VT) || (ch == dls_pkg::CH_FF) ||
                    (ch == dls_pkg::CH_CR);
  assign sym      = dls_pkg::sym_code(ch);
  assign line_sat = (line == LINE_MAX) ? line : line + LINE_ONE;
  assign len_sat  = (len == LEN_MAX) ? len : len + LENGTH_BITS'(1);

  // Finished identifier: keyword if a surviving keyword has the same length
  always_comb begin
    id_kind = dls_pkg::KIND_ID;
    for (int k = 3; k >= 0; k--) begin
      if (kw[k] && len == LENGTH_BITS'(dls_pkg::kw_len(2'(k)))) begin
        id_kind = dls_pkg::KIND_KW0 + dls_pkg::KIND_W'(k);
      end
    end
  end

  // Next state and token slots
  always_comb begin
    mode_next = mode;
    line_next = line;
    tsl_next  = tsl;
    len_next  = len;
    kw_next   = kw;
    do_idle   = 1'b0;
    pend_v    = 1'b0;
    pend_kind = dls_pkg::KIND_ID;
    pend_line = tsl;
    pend_len  = len;
    idle_v    = 1'b0;
    idle_kind = dls_pkg::KIND_UNDEF;
    idle_line = line;
    idle_len  = LENGTH_BITS'(1);

    if (ch == dls_pkg::CH_EOT) begin
      // End of text: flush pending token, then eof
      case (mode)
        dls_pkg::MODE_COLON: begin
          pend_v    = 1'b1;
          pend_kind = dls_pkg::KIND_COLON;
        end
        dls_pkg::MODE_STR: begin
          pend_v    = 1'b1;
          pend_kind = dls_pkg::KIND_UNDEF;
        end
        dls_pkg::MODE_STRQ: begin
          pend_v    = 1'b1;
          pend_kind = dls_pkg::KIND_STRING;
        end
        dls_pkg::MODE_ID: begin
          pend_v    = 1'b1;
          pend_kind = id_kind;
        end
        default: ;
      endcase
      idle_v    = 1'b1;
      idle_kind = dls_pkg::KIND_EOF;
      idle_len  = '0;
      mode_next = dls_pkg::MODE_IDLE;
      line_next = LINE_ONE;
      tsl_next  = LINE_ONE;
      len_next  = '0;
      kw_next   = 4'hF;
    end else begin
      case (mode)
        dls_pkg::MODE_COLON: begin
          pend_v = 1'b1;
          if (ch == dls_pkg::CH_DASH) begin
            pend_kind = dls_pkg::KIND_COLONDASH;
            pend_len  = LENGTH_BITS'(2);
            mode_next = dls_pkg::MODE_IDLE;
          end else begin
            pend_kind = dls_pkg::KIND_COLON;
            do_idle   = 1'b1;
          end
        end
        dls_pkg::MODE_STR: begin
          len_next = len_sat;
          if (ch == dls_pkg::CH_NL) begin
            line_next = line_sat;
          end else if (ch == dls_pkg::CH_QUOTE) begin
            mode_next = dls_pkg::MODE_STRQ;
          end
        end
        dls_pkg::MODE_STRQ: begin
          if (ch == dls_pkg::CH_QUOTE) begin
            len_next  = len_sat;
            mode_next = dls_pkg::MODE_STR;
          end else begin
            pend_v    = 1'b1;
            pend_kind = dls_pkg::KIND_STRING;
            do_idle   = 1'b1;
          end
        end
        dls_pkg::MODE_HASH: begin
          if (ch == dls_pkg::CH_BAR) begin
            mode_next = dls_pkg::MODE_BCOM;
          end else if (ch == dls_pkg::CH_NL) begin
            line_next = line_sat;
            mode_next = dls_pkg::MODE_IDLE;
          end else begin
            mode_next = dls_pkg::MODE_LCOM;
          end
        end
        dls_pkg::MODE_LCOM: begin
          if (ch == dls_pkg::CH_NL) begin
            line_next = line_sat;
            mode_next = dls_pkg::MODE_IDLE;
          end
        end
        dls_pkg::MODE_BCOM: begin
          if (ch == dls_pkg::CH_NL) begin
            line_next = line_sat;
          end else if (ch == dls_pkg::CH_BAR) begin
            mode_next = dls_pkg::MODE_BBAR;
          end
        end
        dls_pkg::MODE_BBAR: begin
          if (ch == dls_pkg::CH_HASH) begin
            mode_next = dls_pkg::MODE_IDLE;
          end else if (ch != dls_pkg::CH_BAR) begin
            if (ch == dls_pkg::CH_NL) line_next = line_sat;
            mode_next = dls_pkg::MODE_BCOM;
          end
        end
        dls_pkg::MODE_ID: begin
          if (is_alpha || is_digit) begin
            kw_next  = kw_step(kw, len, ch);
            len_next = len_sat;
          end else begin
            pend_v    = 1'b1;
            pend_kind = id_kind;
            do_idle   = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Scan the character from the idle mode
      if (do_idle) begin
        mode_next = dls_pkg::MODE_IDLE;
        if (ch == dls_pkg::CH_NL) begin
          line_next = line_sat;
        end else if (is_ws) begin
          // skipped
        end else if (sym[3]) begin
          idle_v    = 1'b1;
          idle_kind = dls_pkg::KIND_COMMA + dls_pkg::KIND_W'(sym[2:0]);
        end else if (ch == dls_pkg::CH_COLON) begin
          mode_next = dls_pkg::MODE_COLON;
          tsl_next  = line;
          len_next  = LENGTH_BITS'(1);
        end else if (ch == dls_pkg::CH_QUOTE) begin
          mode_next = dls_pkg::MODE_STR;
          tsl_next  = line;
          len_next  = LENGTH_BITS'(1);
        end else if (ch == dls_pkg::CH_HASH) begin
          mode_next = dls_pkg::MODE_HASH;
        end else if (is_alpha) begin
          mode_next = dls_pkg::MODE_ID;
          tsl_next  = line;
          kw_next   = kw_step(4'hF, '0, ch);
          len_next  = LENGTH_BITS'(1);
        end else begin
          idle_v    = 1'b1;
          idle_kind = dls_pkg::KIND_UNDEF;
        end
      end
    end
  end

  // Compact the two slots: pending token first, last mark on the final one
  always_comb begin
    push.first  = pend_v | idle_v;
    push.second = pend_v & idle_v;
    tok0 = pend_v ? {!idle_v, pend_len, pend_line, pend_kind}
                  : {1'b1, idle_len, idle_line, idle_kind};
    tok1 = {1'b1, idle_len, idle_line, idle_kind};
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= dls_pkg::MODE_IDLE;
      line <= LINE_ONE;
      tsl  <= LINE_ONE;
      len  <= '0;
      kw   <= 4'hF;
    end else if (accept) begin
      mode <= mode_next;
      line <= line_next;
      tsl  <= tsl_next;
      len  <= len_next;
      kw   <= kw_next;
    end
  end

endmodule

// ===== hdl/dls_queue.sv =====
// dls_queue: three-entry result queue between the scanner and the output.
// Takes up to two tokens per cycle, hands out one per transfer.
// Depends on dls_pkg.
module dls_queue #(
  parameter int unsigned W = 34
) (
  input  logic           clk,
  input  logic           rst,
  input  dls_pkg::push_t push,
  input  logic [W-1:0]   d0,
  input  logic [W-1:0]   d1,
  input  logic           pop,
  output logic [W-1:0]   head,
  output logic           valid,
  output logic           ready
);

  localparam int unsigned DEPTH = 3;

  logic [W-1:0] entry [DEPTH];
  logic [W-1:0] shifted [DEPTH];
  logic [1:0]   cnt, cnt_next;
  logic [1:0]   base;

  // Entries after a pop
  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_shift
    if (g < DEPTH - 1) begin : g_mid
      assign shifted[g] = pop ? entry[g+1] : entry[g];
    end else begin : g_end
      assign shifted[g] = entry[g];
    end
  end

  assign base     = cnt - {1'b0, pop};
  assign cnt_next = base + {1'b0, push.first} + {1'b0, push.second};
  assign head     = entry[0];
  assign valid    = (cnt != 2'd0);
  assign ready    = (cnt <= 2'd1);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Payload: shift on pop, new tokens land behind the survivors
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.first && 2'(i) == base) begin
        entry[i] <= d0;
      end else if (push.second && 2'(i) == base + 2'd1) begin
        entry[i] <= d1;
      end else begin
        entry[i] <= shifted[i];
      end
    end
  end

endmodule

// ===== hdl/datalog_token_scanner.sv =====
// Datalog token scanner: one character per transfer in, tokens out.
// A token is written into the result queue registers when the character that ends it is accepted.
// Throughput: one character per cycle while s_tready is high; a character that closes
// a pending token and also makes one of its own yields two tokens, handed out one per
// transfer from a three-entry result queue, so the input pauses after such a character.
// Reset (rst, synchronous): idle mode, line 1, queue empty.
module datalog_token_scanner #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  output logic       m_tvalid,
  input  logic       m_tready,
  // token_kind, start_line, token_length from bit 0 up, zero filled to bytes
  output logic [((dls_pkg::KIND_W + LINE_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic       m_tlast    // last_of_item
);

  localparam int unsigned BODY_W  = dls_pkg::KIND_W + LINE_BITS + LENGTH_BITS;
  localparam int unsigned ENTRY_W = 1 + BODY_W;
  localparam int unsigned TDATA_W = ((BODY_W + 7) / 8) * 8;

  dls_pkg::push_t     push, push_acc;
  logic [ENTRY_W-1:0] tok0, tok1, head;
  logic               accept;

  assign accept = s_tvalid & s_tready;

  // Tokens only enter the queue on an accepted character
  assign push_acc.first  = push.first & accept;
  assign push_acc.second = push.second & accept;

  dls_core #(
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_tdata),
    .push   (push),
    .tok0   (tok0),
    .tok1   (tok1)
  );

  dls_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push_acc),
    .d0    (tok0),
    .d1    (tok1),
    .pop   (m_tvalid & m_tready),
    .head  (head),
    .valid (m_tvalid),
    .ready (s_tready)
  );

  // Output packing
  assign m_tdata = TDATA_W'(head[BODY_W-1:0]);
  assign m_tlast = head[ENTRY_W-1];

endmodule

// ===== hdl/dls_checker.sv =====
// dls_checker: port-level assertions for the Datalog token scanner.
// Bound to datalog_token_scanner; depends on dls_pkg.
module dls_checker #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [((dls_pkg::KIND_W + LINE_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input logic       m_tlast
);

  // Reset empties the queue and opens the input
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("scanner not empty after reset");

  // End of text always leaves at least the eof token behind
  a_eof_out: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready && s_tdata == dls_pkg::CH_EOT |=> m_tvalid)
    else $error("no token after end of text");

  // Eof is always the final token of its character
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tdata[4:0] == dls_pkg::KIND_EOF |-> m_tlast)
    else $error("eof token without last mark");

  // Kind stays within the defined codes
  a_kind: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[4:0] <= dls_pkg::KIND_EOF)
    else $error("token kind out of range");

  // A stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

endmodule

bind datalog_token_scanner dls_checker #(
  .LINE_BITS   (LINE_BITS),
  .LENGTH_BITS (LENGTH_BITS)
) u_dls_checker (.*);

// ===== tb/sv/datalog_token_checker.sv =====
`timescale 1ns / 1ps
// Token checker for the Datalog token scanner: watches both stream channels.
// Predicts the tokens of every accepted character and compares the results.
// Depends on dls_pkg for mode, kind and character codes.
module datalog_token_checker
  import dls_pkg::*;
#(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 12,
  parameter int unsigned TDATA_W     = ((KIND_W + LINE_BITS + LENGTH_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] ch
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,   // token_kind, start_line, token_length
  input  logic               m_tlast,   // last_of_item
  output int                 fail_count,
  output int                 pending_tokens,
  output int                 tokens_seen,
  output int                 chars_seen
);

  localparam logic [LINE_BITS-1:0]   LINE_SAT = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_SAT  = {LENGTH_BITS{1'b1}};

  typedef struct {
    logic [KIND_W-1:0]      tkind;
    logic [LINE_BITS-1:0]   tline;
    logic [LENGTH_BITS-1:0] tlen;
    logic                   tlast;
  } token_t;

  string      kw_word[4]   = '{"Schemes", "Facts", "Rules", "Queries"};
  logic [7:0] sym_chars[7] = '{",", ".", "?", "(", ")", "*", "+"};

  // Scanner state as predicted
  mode_t                  scan_st  = MODE_IDLE;
  logic [LINE_BITS-1:0]   cur_line = LINE_BITS'(1);
  logic [LINE_BITS-1:0]   tok_line = LINE_BITS'(1);
  logic [LENGTH_BITS-1:0] tok_len  = '0;
  logic [3:0]             kw_live  = 4'hF;

  token_t predicted_tokens[$];
  token_t char_tokens[2];
  int     n_char_tokens;
  int     fails = 0;
  int     seen  = 0;
  int     chars = 0;

  token_t                 want;
  logic [KIND_W-1:0]      got_kind;
  logic [LINE_BITS-1:0]   got_line;
  logic [LENGTH_BITS-1:0] got_len;

  function automatic void add_token(input logic [KIND_W-1:0] k,
                                    input logic [LINE_BITS-1:0] ln,
                                    input logic [LENGTH_BITS-1:0] n);
    char_tokens[n_char_tokens] = '{tkind: k, tline: ln, tlen: n, tlast: 1'b0};
    n_char_tokens++;
  endfunction

  function automatic void bump_line();
    if (cur_line != LINE_SAT) cur_line++;
  endfunction

  function automatic void bump_len();
    if (tok_len != LEN_SAT) tok_len++;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Identifier character: drop keywords that no longer match
  function automatic void id_char(input logic [7:0] c);
    for (int k = 0; k < 4; k++) begin
      if (tok_len >= kw_word[k].len() || kw_word[k][int'(tok_len)] != c)
        kw_live[k] = 1'b0;
    end
    bump_len();
  endfunction

  function automatic void id_close();
    logic [KIND_W-1:0] k_out;
    bit                hit;
    k_out = KIND_ID;
    hit   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!hit && kw_live[k] && tok_len == kw_word[k].len()) begin
        k_out = KIND_KW0 + KIND_W'(k);
        hit   = 1'b1;
      end
    end
    add_token(k_out, tok_line, tok_len);
  endfunction

  // Character seen with nothing open
  function automatic void scan_plain(input logic [7:0] c);
    bit hit;
    hit     = 1'b0;
    scan_st = MODE_IDLE;
    if (c == CH_NL) begin
      bump_line();
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) begin
      hit = 1'b1;
    end else begin
      for (int i = 0; i < 7; i++) begin
        if (!hit && c == sym_chars[i]) begin
          add_token(KIND_COMMA + KIND_W'(i), cur_line, LENGTH_BITS'(1));
          hit = 1'b1;
        end
      end
      if (hit) begin
      end else if (c == CH_COLON) begin
        scan_st  = MODE_COLON;
        tok_line = cur_line;
        tok_len  = LENGTH_BITS'(1);
      end else if (c == CH_QUOTE) begin
        scan_st  = MODE_STR;
        tok_line = cur_line;
        tok_len  = LENGTH_BITS'(1);
      end else if (c == CH_HASH) begin
        scan_st = MODE_HASH;
      end else if (is_letter(c)) begin
        scan_st  = MODE_ID;
        tok_line = cur_line;
        tok_len  = '0;
        kw_live  = 4'hF;
        id_char(c);
      end else begin
        add_token(KIND_UNDEF, cur_line, LENGTH_BITS'(1));
      end
    end
  endfunction

  function automatic void clear_scan();
    scan_st  = MODE_IDLE;
    cur_line = LINE_BITS'(1);
    tok_line = LINE_BITS'(1);
    tok_len  = '0;
    kw_live  = 4'hF;
  endfunction

  // Predict the tokens one character produces and queue them
  function automatic void scan_char(input logic [7:0] c);
    n_char_tokens = 0;
    if (c == CH_EOT) begin
      case (scan_st)
        MODE_COLON: add_token(KIND_COLON, tok_line, tok_len);
        MODE_STR:   add_token(KIND_UNDEF, tok_line, tok_len);
        MODE_STRQ:  add_token(KIND_STRING, tok_line, tok_len);
        MODE_ID:    id_close();
        default: ;
      endcase
      add_token(KIND_EOF, cur_line, '0);
      clear_scan();
    end else begin
      case (scan_st)
        MODE_COLON: begin
          if (c == CH_DASH) begin
            add_token(KIND_COLONDASH, tok_line, LENGTH_BITS'(2));
            scan_st = MODE_IDLE;
          end else begin
            add_token(KIND_COLON, tok_line, tok_len);
            scan_plain(c);
          end
        end
        MODE_STR: begin
          bump_len();
          if (c == CH_NL) bump_line();
          else if (c == CH_QUOTE) scan_st = MODE_STRQ;
        end
        MODE_STRQ: begin
          // doubled quote is an escape, anything else closes the string
          if (c == CH_QUOTE) begin
            bump_len();
            scan_st = MODE_STR;
          end else begin
            add_token(KIND_STRING, tok_line, tok_len);
            scan_plain(c);
          end
        end
        MODE_HASH: begin
          if (c == CH_BAR) begin
            scan_st = MODE_BCOM;
          end else if (c == CH_NL) begin
            bump_line();
            scan_st = MODE_IDLE;
          end else begin
            scan_st = MODE_LCOM;
          end
        end
        MODE_LCOM: begin
          if (c == CH_NL) begin
            bump_line();
            scan_st = MODE_IDLE;
          end
        end
        MODE_BCOM: begin
          if (c == CH_NL) bump_line();
          else if (c == CH_BAR) scan_st = MODE_BBAR;
        end
        MODE_BBAR: begin
          if (c == CH_HASH) begin
            scan_st = MODE_IDLE;
          end else if (c != CH_BAR) begin
            if (c == CH_NL) bump_line();
            scan_st = MODE_BCOM;
          end
        end
        MODE_ID: begin
          if (is_letter(c) || is_digit(c)) begin
            id_char(c);
          end else begin
            id_close();
            scan_plain(c);
          end
        end
        default: scan_plain(c);
      endcase
    end
    if (n_char_tokens > 0) char_tokens[n_char_tokens-1].tlast = 1'b1;
    for (int i = 0; i < n_char_tokens; i++) predicted_tokens = {predicted_tokens, char_tokens[i]};
  endfunction

  // Compare each output transfer, then predict from each input transfer
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      predicted_tokens.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_kind = m_tdata[KIND_W-1:0];
        got_line = m_tdata[KIND_W +: LINE_BITS];
        got_len  = m_tdata[KIND_W + LINE_BITS +: LENGTH_BITS];
        if (predicted_tokens.size() == 0) begin
          $display("%0t: unexpected token kind=%0d line=%0d len=%0d last=%0b",
                   $time, got_kind, got_line, got_len, m_tlast);
          fails++;
        end else begin
          want = predicted_tokens.pop_front();
          if (got_kind !== want.tkind || got_line !== want.tline ||
              got_len !== want.tlen || m_tlast !== want.tlast) begin
            $display("%0t: token %0d mismatch: expected kind=%0d line=%0d len=%0d last=%0b",
                     $time, seen, want.tkind, want.tline, want.tlen, want.tlast);
            $display("%0t: token %0d mismatch:   actual kind=%0d line=%0d len=%0d last=%0b",
                     $time, seen, got_kind, got_line, got_len, m_tlast);
            fails++;
          end
          seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        scan_char(s_tdata);
        chars++;
      end
    end
    fail_count     <= fails;
    pending_tokens <= predicted_tokens.size();
    tokens_seen    <= seen;
    chars_seen     <= chars;
  end

endmodule

// ===== tb/sv/datalog_token_scanner_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Datalog token scanner: clock, reset, character stimulus
// with bursty sending and a stalling token sink. Depends on dls_pkg, the scanner
// and datalog_token_checker, which does all prediction and comparison.
module datalog_token_scanner_tb;
  import dls_pkg::*;

  localparam int unsigned TDATA_W    = ((KIND_W + 16 + 12 + 7) / 8) * 8;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          RAND_CHARS = 520;
  localparam int          LONG_LINES = 40;

  logic               clk;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = 8'h00;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  int fail_count;
  int pending_tokens;
  int tokens_seen;
  int chars_seen;

  int burst_left   = 0;
  int chars_sent   = 0;
  int stall_style  = 0;
  int style_left   = 0;
  int quiet_cycles = 0;

  string kw_names[4] = '{"Schemes", "Facts", "Rules", "Queries"};
  string sym_text    = ",.?()*+";

  datalog_token_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  datalog_token_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_seen    (tokens_seen),
    .chars_seen     (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Token sink: switches between stall patterns
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(16, 160);
    end else begin
      style_left--;
    end
    case (stall_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // One character transfer; bursts separated by random gaps
  task automatic put_char(input logic [7:0] c);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
    end
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // Hold the sender until every predicted token has come out
  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_tokens != 0) @(negedge clk);
    burst_left = $urandom_range(1, 16);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'("0") + 8'($urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_NL;
    endcase
  endfunction

  // One random piece of Datalog-like text, or noise
  task automatic put_fragment();
    int    sel;
    int    n;
    string word;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      // keywords and near misses
      word = kw_names[$urandom_range(0, 3)];
      case ($urandom_range(0, 3))
        0: put_text(word.substr(0, word.len() - 2));
        1: begin
          put_text(word);
          put_char(rand_alnum());
        end
        2: begin
          put_char(word[0] ^ 8'h20);
          put_text(word.substr(1, word.len() - 1));
        end
        default: put_text(word);
      endcase
    end else if (sel < 35) begin
      put_char(rand_letter());
      n = $urandom_range(0, 7);
      repeat (n) put_char(rand_alnum());
    end else if (sel < 50) begin
      case ($urandom_range(0, 8))
        7:       put_text(":-");
        8:       put_char(CH_COLON);
        default: put_char(sym_text[$urandom_range(0, 6)]);
      endcase
    end else if (sel < 60) begin
      // string with escapes and embedded newlines
      put_char(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       put_text("''");
          1:       put_char(CH_NL);
          2:       put_char(CH_SPACE);
          default: put_char(rand_alnum());
        endcase
      end
      if ($urandom_range(0, 7) != 0) put_char(CH_QUOTE);
    end else if (sel < 80) begin
      put_char(rand_space());
    end else if (sel < 83) begin
      put_char(CH_HASH);
      n = $urandom_range(0, 5);
      repeat (n) put_char(8'($urandom_range(32, 126)));
      put_char(CH_NL);
    end else if (sel < 88) begin
      put_text("#|");
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       put_char(CH_BAR);
          1:       put_char(CH_NL);
          2:       put_char(CH_HASH);
          default: put_char(rand_alnum());
        endcase
      end
      case ($urandom_range(0, 7))
        0:       ;
        1:       put_text("||#");
        default: put_text("|#");
      endcase
    end else if (sel < 96) begin
      put_char(8'($urandom_range(1, 255)));
    end else if (sel < 98) begin
      put_char(CH_EOT);
    end else begin
      put_char(CH_HASH);
      put_char(CH_NL);
    end
  endtask

  initial begin
    int rand_start;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: all symbols, colon-dash and a bare colon, a string holding an
    // escaped quote, a keyword ended by a block comment, a high byte, a line
    // comment, and an unterminated string at end of text
    put_text(",.?()*+:-:''''Rules#||#");
    put_char(8'hFF);
    put_text("#c\n'z");
    put_char(CH_EOT);
    drain_tokens();

    // String full of newlines: lines and length count inside the string
    put_char(CH_QUOTE);
    repeat (LONG_LINES) put_char(CH_NL);
    put_text("'x\n,");
    put_char(CH_EOT);
    drain_tokens();

    // Random text, with one full drain half way
    rand_start = chars_sent;
    while (chars_sent - rand_start < RAND_CHARS / 2) put_fragment();
    drain_tokens();
    while (chars_sent - rand_start < RAND_CHARS) put_fragment();
    put_char(CH_EOT);

    drain_tokens();
    repeat (8) @(negedge clk);
    $display("sent %0d characters, checked %0d tokens: symbols, strings, comments,",
             chars_seen, tokens_seen);
    $display("keywords, undefined bytes, end-of-text restarts and multi-line strings");
    if (fail_count == 0 && pending_tokens == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d tokens never seen", fail_count, pending_tokens);
      $display("status: fail");
    end
    $finish;
  end

endmodule
